// ===== design/bnr_pkg.sv =====
// Shared types and constants for the byte/nibble RAM copy and fill unit.
// Used by bnr_ctrl, bnr_datapath and the top level; no dependencies.
package bnr_pkg;

    localparam int RAM_BYTES = 65536;
    localparam int ADDR_W    = $clog2(RAM_BYTES);
    localparam int CNT_W     = $clog2(RAM_BYTES + 1);

    localparam logic [7:0] LO_MASK = 8'h0F;
    localparam logic [7:0] HI_MASK = 8'hF0;

    typedef enum logic [2:0] {
        CMD_BYTE_RD = 3'd0,
        CMD_NIB_RD  = 3'd1,
        CMD_BYTE_WR = 3'd2,
        CMD_NIB_WR  = 3'd3,
        CMD_COPY    = 3'd4,
        CMD_FILL    = 3'd5
    } cmd_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RD_BYTE,
        ST_RD_NIB,
        ST_RMW,
        ST_COPY_RD,
        ST_COPY_WR,
        ST_FILL
    } state_t;

    typedef enum logic [1:0] {
        RD_IN_BYTE,
        RD_IN_NIB,
        RD_SPTR
    } rd_sel_t;

    typedef enum logic [1:0] {
        WR_IN_BYTE,
        WR_NIB,
        WR_FILL,
        WR_COPY
    } wr_sel_t;

    typedef enum logic [1:0] {
        RES_ZERO,
        RES_OOR,
        RES_BYTE,
        RES_NIB
    } res_sel_t;

    typedef struct packed {
        logic     load;
        logic     ram_rd;
        rd_sel_t  rd_sel;
        logic     ram_wr;
        wr_sel_t  wr_sel;
        logic     step;
        logic     res_load;
        res_sel_t res_sel;
    } ctrl_t;

    typedef struct packed {
        logic in_range;
        logic cnt_zero;
        logic cnt_last;
        logic res_free;
    } status_t;

endpackage

// ===== design/byte_nibble_ram_copy_fill_unit.sv =====
// Top level of the byte/nibble RAM copy and fill unit.
// Depends on bnr_pkg, bnr_ctrl and bnr_datapath.
//
//  channel   | dir | tdata (low bit up)                        | tuser
//  ----------+-----+-------------------------------------------+-------------
//  s (cmd)   | in  | dest_address, source_address, data_value, | cmd
//            |     | length                                    |
//  m (result)| out | read_data                                 | out_of_range
//
// Byte write, out-of-range and unused commands finish in the accepting state; reads
// and nibble write go on to a read-out or write-back state (one RAM read port with
// registered data). Fill writes each clipped byte in ST_FILL; copy reads each one
// in ST_COPY_RD and then writes it in ST_COPY_WR over the same single-ported RAM.
// Reset clears only the sequencer and result valid; RAM contents are undefined
// until written. A new beat is taken while a result waits, as long as the
// result register frees up in the same cycle.
module byte_nibble_ram_copy_fill_unit (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          s_tvalid,
    output logic          s_tready,
    input  logic [103:0]  s_tdata,  // dest_address, source_address, data_value, length
    input  logic [2:0]    s_tuser,  // cmd
    output logic          m_tvalid,
    input  logic          m_tready,
    output logic [7:0]    m_tdata,  // read_data
    output logic [0:0]    m_tuser   // out_of_range
);

    bnr_pkg::ctrl_t   ctrl;
    bnr_pkg::status_t status;

    bnr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tuser  (s_tuser),
        .status   (status),
        .ctrl     (ctrl)
    );

    bnr_datapath u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tuser  (s_tuser),
        .s_tdata  (s_tdata),
        .ctrl     (ctrl),
        .status   (status),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule

// ===== design/bnr_ctrl.sv =====
// Command sequencer for the byte/nibble RAM copy and fill unit.
// Depends on bnr_pkg; drives the datapath through bnr_pkg::ctrl_t.
module bnr_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [2:0]        s_tuser,
    input  bnr_pkg::status_t  status,
    output bnr_pkg::ctrl_t    ctrl
);

    bnr_pkg::state_t state_reg;
    bnr_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= bnr_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        s_tready      = 1'b0;
        ctrl.load     = 1'b0;
        ctrl.ram_rd   = 1'b0;
        ctrl.rd_sel   = bnr_pkg::RD_IN_BYTE;
        ctrl.ram_wr   = 1'b0;
        ctrl.wr_sel   = bnr_pkg::WR_IN_BYTE;
        ctrl.step     = 1'b0;
        ctrl.res_load = 1'b0;
        ctrl.res_sel  = bnr_pkg::RES_ZERO;

        unique case (state_reg)
            bnr_pkg::ST_IDLE:
            begin
                s_tready = status.res_free;
                if (s_tvalid && status.res_free)
                begin
                    ctrl.load = 1'b1;
                    if (!status.in_range)
                    begin
                        // bad start address: flag and ignore
                        ctrl.res_load = 1'b1;
                        ctrl.res_sel  = bnr_pkg::RES_OOR;
                    end
                    else
                    begin
                        case (bnr_pkg::cmd_t'(s_tuser))
                            bnr_pkg::CMD_BYTE_RD:
                            begin
                                ctrl.ram_rd = 1'b1;
                                ctrl.rd_sel = bnr_pkg::RD_IN_BYTE;
                                state_next  = bnr_pkg::ST_RD_BYTE;
                            end
                            bnr_pkg::CMD_NIB_RD:
                            begin
                                ctrl.ram_rd = 1'b1;
                                ctrl.rd_sel = bnr_pkg::RD_IN_NIB;
                                state_next  = bnr_pkg::ST_RD_NIB;
                            end
                            bnr_pkg::CMD_BYTE_WR:
                            begin
                                ctrl.ram_wr   = 1'b1;
                                ctrl.wr_sel   = bnr_pkg::WR_IN_BYTE;
                                ctrl.res_load = 1'b1;
                            end
                            bnr_pkg::CMD_NIB_WR:
                            begin
                                ctrl.ram_rd = 1'b1;
                                ctrl.rd_sel = bnr_pkg::RD_IN_NIB;
                                state_next  = bnr_pkg::ST_RMW;
                            end
                            bnr_pkg::CMD_COPY:
                            begin
                                if (status.cnt_zero)
                                begin
                                    ctrl.res_load = 1'b1;
                                end
                                else
                                begin
                                    state_next = bnr_pkg::ST_COPY_RD;
                                end
                            end
                            bnr_pkg::CMD_FILL:
                            begin
                                if (status.cnt_zero)
                                begin
                                    ctrl.res_load = 1'b1;
                                end
                                else
                                begin
                                    state_next = bnr_pkg::ST_FILL;
                                end
                            end
                            default:
                            begin
                                // unused codes: answer zero, not flagged
                                ctrl.res_load = 1'b1;
                            end
                        endcase
                    end
                end
            end
            bnr_pkg::ST_RD_BYTE:
            begin
                ctrl.res_load = 1'b1;
                ctrl.res_sel  = bnr_pkg::RES_BYTE;
                state_next    = bnr_pkg::ST_IDLE;
            end
            bnr_pkg::ST_RD_NIB:
            begin
                ctrl.res_load = 1'b1;
                ctrl.res_sel  = bnr_pkg::RES_NIB;
                state_next    = bnr_pkg::ST_IDLE;
            end
            bnr_pkg::ST_RMW:
            begin
                ctrl.ram_wr   = 1'b1;
                ctrl.wr_sel   = bnr_pkg::WR_NIB;
                ctrl.res_load = 1'b1;
                state_next    = bnr_pkg::ST_IDLE;
            end
            bnr_pkg::ST_COPY_RD:
            begin
                ctrl.ram_rd = 1'b1;
                ctrl.rd_sel = bnr_pkg::RD_SPTR;
                state_next  = bnr_pkg::ST_COPY_WR;
            end
            bnr_pkg::ST_COPY_WR:
            begin
                ctrl.ram_wr = 1'b1;
                ctrl.wr_sel = bnr_pkg::WR_COPY;
                ctrl.step   = 1'b1;
                if (status.cnt_last)
                begin
                    ctrl.res_load = 1'b1;
                    state_next    = bnr_pkg::ST_IDLE;
                end
                else
                begin
                    state_next = bnr_pkg::ST_COPY_RD;
                end
            end
            bnr_pkg::ST_FILL:
            begin
                ctrl.ram_wr = 1'b1;
                ctrl.wr_sel = bnr_pkg::WR_FILL;
                ctrl.step   = 1'b1;
                if (status.cnt_last)
                begin
                    ctrl.res_load = 1'b1;
                    state_next    = bnr_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = bnr_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

// ===== design/bnr_datapath.sv =====
// RAM, address and count registers, bounds checks and result register.
// Depends on bnr_pkg; steered by bnr_ctrl through bnr_pkg::ctrl_t.
module bnr_datapath (
    input  logic              clk,
    input  logic              rst_n,
    input  logic [2:0]        s_tuser,
    input  logic [103:0]      s_tdata,
    input  bnr_pkg::ctrl_t    ctrl,
    output bnr_pkg::status_t  status,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [7:0]        m_tdata,
    output logic [0:0]        m_tuser
);

    localparam int AW = bnr_pkg::ADDR_W;
    localparam int CW = bnr_pkg::CNT_W;

    logic [7:0] mem [bnr_pkg::RAM_BYTES];

    logic [31:0] in_dest;
    logic [31:0] in_src;
    logic [7:0]  in_val;
    logic [31:0] in_len;
    bnr_pkg::cmd_t in_cmd;

    logic [AW-1:0] dptr_reg;
    logic [AW-1:0] sptr_reg;
    logic [7:0]    val_reg;
    logic          nib_odd_reg;
    logic [CW-1:0] cnt_reg;
    logic [7:0]    rdata_reg;
    logic [7:0]    read_data_reg;
    logic          oor_reg;
    logic          res_valid_reg;
    logic          res_valid_next;

    logic          dest_ok;
    logic          src_ok;
    logic          nib_ok;
    logic          is_nib;
    logic [CW-1:0] room_d;
    logic [CW-1:0] room_s;
    logic [CW-1:0] room;
    logic [CW-1:0] count;
    logic [AW-1:0] raddr;
    logic [AW-1:0] waddr;
    logic [7:0]    wdata;
    logic [7:0]    rmw_byte;
    logic [7:0]    nib_rd;
    logic [7:0]    res_data;

    assign in_dest = s_tdata[31:0];
    assign in_src  = s_tdata[63:32];
    assign in_val  = s_tdata[71:64];
    assign in_len  = s_tdata[103:72];
    assign in_cmd  = bnr_pkg::cmd_t'(s_tuser);

    assign dest_ok = in_dest < 32'(bnr_pkg::RAM_BYTES);
    assign src_ok  = in_src  < 32'(bnr_pkg::RAM_BYTES);
    assign nib_ok  = in_dest < 32'(2 * bnr_pkg::RAM_BYTES);
    assign is_nib  = (in_cmd == bnr_pkg::CMD_NIB_RD) || (in_cmd == bnr_pkg::CMD_NIB_WR);

    // room left to the end of RAM, valid only when the start is in range
    assign room_d = CW'(bnr_pkg::RAM_BYTES) - CW'(in_dest[AW-1:0]);
    assign room_s = CW'(bnr_pkg::RAM_BYTES) - CW'(in_src[AW-1:0]);
    assign room   = (in_cmd == bnr_pkg::CMD_COPY && room_s < room_d) ? room_s : room_d;
    assign count  = (in_len < 32'(room)) ? in_len[CW-1:0] : room;

    always_comb
    begin
        case (in_cmd)
            bnr_pkg::CMD_BYTE_RD,
            bnr_pkg::CMD_BYTE_WR,
            bnr_pkg::CMD_FILL:    status.in_range = dest_ok;
            bnr_pkg::CMD_NIB_RD,
            bnr_pkg::CMD_NIB_WR:  status.in_range = nib_ok;
            bnr_pkg::CMD_COPY:    status.in_range = dest_ok && src_ok;
            default:              status.in_range = 1'b1;
        endcase
        status.cnt_zero = (count == '0);
        status.cnt_last = (cnt_reg == CW'(1));
        status.res_free = !res_valid_reg || m_tready;
    end

    always_comb
    begin
        case (ctrl.rd_sel)
            bnr_pkg::RD_IN_BYTE: raddr = in_dest[AW-1:0];
            bnr_pkg::RD_IN_NIB:  raddr = in_dest[AW:1];
            default:             raddr = sptr_reg;
        endcase
    end

    // odd nibble address ORs the whole data byte over the kept high nibble
    assign rmw_byte = nib_odd_reg ? ((rdata_reg & bnr_pkg::HI_MASK) | val_reg)
                                  : ((rdata_reg & bnr_pkg::LO_MASK) | {val_reg[3:0], 4'h0});

    always_comb
    begin
        case (ctrl.wr_sel)
            bnr_pkg::WR_IN_BYTE:
            begin
                waddr = in_dest[AW-1:0];
                wdata = in_val;
            end
            bnr_pkg::WR_NIB:
            begin
                waddr = dptr_reg;
                wdata = rmw_byte;
            end
            bnr_pkg::WR_FILL:
            begin
                waddr = dptr_reg;
                wdata = val_reg;
            end
            default:
            begin
                waddr = dptr_reg;
                wdata = rdata_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.ram_wr)
        begin
            mem[waddr] <= wdata;
        end
        if (ctrl.ram_rd)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            dptr_reg    <= is_nib ? in_dest[AW:1] : in_dest[AW-1:0];
            sptr_reg    <= in_src[AW-1:0];
            val_reg     <= in_val;
            nib_odd_reg <= in_dest[0];
            cnt_reg     <= count;
        end
        else if (ctrl.step)
        begin
            dptr_reg <= dptr_reg + AW'(1);
            sptr_reg <= sptr_reg + AW'(1);
            cnt_reg  <= cnt_reg - CW'(1);
        end
    end

    assign nib_rd = nib_odd_reg ? (rdata_reg & bnr_pkg::LO_MASK) : {4'h0, rdata_reg[7:4]};

    always_comb
    begin
        case (ctrl.res_sel)
            bnr_pkg::RES_BYTE: res_data = rdata_reg;
            bnr_pkg::RES_NIB:  res_data = nib_rd;
            default:           res_data = 8'h00;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.res_load)
        begin
            read_data_reg <= res_data;
            oor_reg       <= (ctrl.res_sel == bnr_pkg::RES_OOR);
        end
    end

    always_comb
    begin
        if (ctrl.res_load)
        begin
            res_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            res_valid_next = 1'b0;
        end
        else
        begin
            res_valid_next = res_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else
        begin
            res_valid_reg <= res_valid_next;
        end
    end

    assign m_tvalid = res_valid_reg;
    assign m_tdata  = read_data_reg;
    assign m_tuser  = oor_reg;

endmodule

// ===== test/bnr_result_checker.sv =====
// Result checker for the byte/nibble RAM copy and fill unit.
// Mirrors the RAM in a local array, predicts every answer and compares each result beat.
// Depends on bnr_pkg for the command codes, masks and RAM size.
module bnr_result_checker
    import bnr_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    input  logic         s_tready,
    input  logic [103:0] s_tdata,  // dest_address, source_address, data_value, length
    input  logic [2:0]   s_tuser,  // cmd
    input  logic         m_tvalid,
    input  logic         m_tready,
    input  logic [7:0]   m_tdata,  // read_data
    input  logic [0:0]   m_tuser,  // out_of_range
    output int           errors,
    output int           pending
);

    typedef struct packed {
        logic [7:0] read_data;
        logic       out_of_range;
    } answer_t;

    localparam int              MAX_REPORTS = 40;
    localparam longint unsigned NIB_SPAN    = 2 * RAM_BYTES;

    logic [7:0] ram_image [RAM_BYTES];
    answer_t    answer_queue [$];
    answer_t    want;

    function automatic longint unsigned clip_to_ram(input longint unsigned start,
                                                    input longint unsigned count);
        longint unsigned room;
        room = RAM_BYTES - start;
        return (count < room) ? count : room;
    endfunction

    // Apply one command to the RAM image and return the answer it should produce.
    function automatic answer_t run_command(input logic [2:0] cmd, input logic [31:0] dst,
                                            input logic [31:0] src, input logic [7:0] val,
                                            input logic [31:0] len);
        answer_t         ans;
        logic [7:0]      b;
        longint unsigned n;
        longint unsigned i;
        ans = '0;
        case (cmd)
            CMD_BYTE_RD:
                if (dst < RAM_BYTES)
                    ans.read_data = ram_image[dst];
                else
                    ans.out_of_range = 1'b1;
            CMD_NIB_RD:
                if (dst < NIB_SPAN)
                begin
                    b = ram_image[dst >> 1];
                    ans.read_data = dst[0] ? (b & LO_MASK) : (b >> 4);
                end
                else
                    ans.out_of_range = 1'b1;
            CMD_BYTE_WR:
                if (dst < RAM_BYTES)
                    ram_image[dst] = val;
                else
                    ans.out_of_range = 1'b1;
            CMD_NIB_WR:
                if (dst < NIB_SPAN)
                begin
                    b = ram_image[dst >> 1];
                    // odd address: whole value byte is ORed in, high bits included
                    if (dst[0])
                        b = (b & HI_MASK) | val;
                    else
                        b = (b & LO_MASK) | {val[3:0], 4'h0};
                    ram_image[dst >> 1] = b;
                end
                else
                    ans.out_of_range = 1'b1;
            CMD_COPY:
                if (dst < RAM_BYTES && src < RAM_BYTES)
                begin
                    n = clip_to_ram(dst, clip_to_ram(src, len));
                    // forward order: overlap with dest above source repeats the pattern
                    for (i = 0; i < n; i++)
                        ram_image[dst + i] = ram_image[src + i];
                end
                else
                    ans.out_of_range = 1'b1;
            CMD_FILL:
                if (dst < RAM_BYTES)
                begin
                    n = clip_to_ram(dst, len);
                    for (i = 0; i < n; i++)
                        ram_image[dst + i] = val;
                end
                else
                    ans.out_of_range = 1'b1;
            default:
                ;
        endcase
        return ans;
    endfunction

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            // retire the result beat first: it always belongs to an earlier command
            if (m_tvalid && m_tready)
            begin
                if (answer_queue.size() == 0)
                begin
                    if (errors < MAX_REPORTS)
                        $display("%0t: unexpected result, expected none got %02h/%0b",
                                 $time, m_tdata, m_tuser);
                    errors++;
                end
                else
                begin
                    want = answer_queue.pop_front();
                    if (m_tdata !== want.read_data)
                    begin
                        if (errors < MAX_REPORTS)
                            $display("%0t: read_data mismatch, expected %02h got %02h",
                                     $time, want.read_data, m_tdata);
                        errors++;
                    end
                    if (m_tuser[0] !== want.out_of_range)
                    begin
                        if (errors < MAX_REPORTS)
                            $display("%0t: out_of_range mismatch, expected %0b got %0b",
                                     $time, want.out_of_range, m_tuser[0]);
                        errors++;
                    end
                end
            end
            if (s_tvalid && s_tready)
                answer_queue.push_back(run_command(s_tuser, s_tdata[31:0], s_tdata[63:32],
                                                   s_tdata[71:64], s_tdata[103:72]));
            pending = answer_queue.size();
        end
    end

endmodule

// ===== test/byte_nibble_ram_copy_fill_unit_tb.sv =====
// Testbench top for the byte/nibble RAM copy and fill unit: clock, reset, command
// stimulus with bursty input and a stalling result side, and the final verdict.
// Depends on bnr_pkg, the unit itself and bnr_result_checker.
module byte_nibble_ram_copy_fill_unit_tb;
    import bnr_pkg::*;

    localparam logic [2:0] CMD_SPARE_6  = 3'd6;
    localparam logic [2:0] CMD_SPARE_7  = 3'd7;
    localparam int         RANDOM_ITEMS = 1725;
    localparam int         HOLD_START   = 300;
    localparam int         HOLD_CYCLES  = 400;
    localparam int         DRAIN_CYCLES = 16;
    localparam int         CYCLE_LIMIT  = 3_000_000;

    logic         clk      = 1'b0;
    logic         rst_n    = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [103:0] s_tdata  = '0;  // dest_address, source_address, data_value, length
    logic [2:0]   s_tuser  = '0;  // cmd
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [7:0]   m_tdata;        // read_data
    logic [0:0]   m_tuser;        // out_of_range
    int           errors;
    int           pending;
    bit           random_phase = 1'b0;
    int           burst_left   = 0;

    byte_nibble_ram_copy_fill_unit dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    bnr_result_checker u_checker (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .errors   (errors),
        .pending  (pending)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    initial
    begin : watchdog
        int cycle_count;
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("tb: failure");
        $finish;
    end

    // Result side: stretches of always ready, coin flips and heavy stalls, plus
    // one long hold-off early in the random phase to back the unit up.
    initial
    begin : result_sink
        int  stretch;
        int  mode;
        int  hold_wait;
        bit  hold_done;
        stretch   = 0;
        mode      = 0;
        hold_wait = 0;
        hold_done = 1'b0;
        wait (rst_n);
        forever
        begin
            @(negedge clk);
            if (random_phase && !hold_done)
            begin
                hold_wait++;
                if (hold_wait == HOLD_START)
                begin
                    m_tready <= 1'b0;
                    repeat (HOLD_CYCLES) @(negedge clk);
                    hold_done = 1'b1;
                end
            end
            if (stretch == 0)
            begin
                mode    = $urandom_range(0, 2);
                stretch = $urandom_range(1, 40);
            end
            stretch--;
            case (mode)
                0:       m_tready <= 1'b1;
                1:       m_tready <= $urandom_range(0, 1);
                default: m_tready <= ($urandom_range(0, 4) == 0);
            endcase
        end
    end

    // Offer one command beat, opening a new burst after a random gap when the
    // current one is used up. Enter and leave at a falling edge.
    task automatic issue(input logic [2:0] cmd, input logic [31:0] dst, input logic [31:0] src,
                         input logic [7:0] val, input logic [31:0] len);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if ($urandom_range(0, 15) == 0)
                gap = 25;
            if (gap != 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            burst_left = $urandom_range(1, 40);
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= {len, val, src, dst};
        s_tuser  <= cmd;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        @(negedge clk);
    endtask

    function automatic logic [31:0] pick_address(input longint unsigned span);
        int p;
        p = $urandom_range(0, 99);
        if (p < 7)
            return $urandom();
        else if (p < 11)
            return 32'(span) + $urandom_range(0, 3);
        else if (p < 20)
            return 32'(span) - 1 - $urandom_range(0, 15);
        else if (p < 60)
            return $urandom_range(0, 255);
        else
            return $urandom_range(0, 32'(span - 1));
    endfunction

    initial
    begin : stimulus
        int          n;
        int          p;
        logic [2:0]  cmd;
        logic [31:0] dst;
        logic [31:0] src;
        logic [7:0]  val;
        logic [31:0] len;

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // whole-RAM fill first, so no read ever touches an unwritten byte
        issue(CMD_FILL,    32'd0, 32'd0, 8'hA5, 32'hFFFF_FFFF);
        issue(CMD_BYTE_RD, 32'd0, 32'd0, 8'h00, 32'd0);
        issue(CMD_BYTE_RD, 32'(RAM_BYTES - 1), 32'hFFFF_FFFF, 8'hFF, 32'hFFFF_FFFF);
        issue(CMD_BYTE_WR, 32'd0, 32'd0, 8'hFF, 32'd0);
        issue(CMD_BYTE_WR, 32'(RAM_BYTES - 1), 32'd0, 8'h3C, 32'd0);
        issue(CMD_BYTE_WR, 32'hFFFF_FFFF, 32'd0, 8'h12, 32'd0);
        issue(CMD_BYTE_RD, 32'(RAM_BYTES), 32'd0, 8'h00, 32'd0);
        // high nibble takes only the low four value bits
        issue(CMD_NIB_WR,  32'd0, 32'd0, 8'hFF, 32'd0);
        // low nibble ORs in the full value byte
        issue(CMD_NIB_WR,  32'd3, 32'd0, 8'hF3, 32'd0);
        issue(CMD_NIB_RD,  32'd0, 32'd0, 8'h00, 32'd0);
        issue(CMD_NIB_RD,  32'd3, 32'd0, 8'h00, 32'd0);
        issue(CMD_NIB_RD,  32'(2 * RAM_BYTES - 1), 32'd0, 8'h00, 32'd0);
        issue(CMD_NIB_RD,  32'(2 * RAM_BYTES), 32'd0, 8'h00, 32'd0);
        issue(CMD_NIB_WR,  32'hFFFF_FFFF, 32'd0, 8'h5A, 32'd0);
        issue(CMD_BYTE_WR, 32'd100, 32'd0, 8'h11, 32'd0);
        issue(CMD_BYTE_WR, 32'd101, 32'd0, 8'h22, 32'd0);
        issue(CMD_BYTE_WR, 32'd102, 32'd0, 8'h33, 32'd0);
        // overlapping copy, dest above source: repeats the three-byte pattern
        issue(CMD_COPY,    32'd103, 32'd100, 8'h00, 32'd20);
        // copy clipped by the source running off the end
        issue(CMD_COPY,    32'd65000, 32'(RAM_BYTES - 6), 8'h00, 32'd100);
        issue(CMD_COPY,    32'd500, 32'd600, 8'h00, 32'd0);
        issue(CMD_FILL,    32'd500, 32'd0, 8'h77, 32'd0);
        issue(CMD_COPY,    32'(RAM_BYTES), 32'd0, 8'h00, 32'd4);
        issue(CMD_COPY,    32'd0, 32'hFFFF_FFFF, 8'h00, 32'd4);
        issue(CMD_FILL,    32'(RAM_BYTES - 6), 32'd0, 8'h5A, 32'hFFFF_FFFF);
        issue(CMD_FILL,    32'(RAM_BYTES), 32'd0, 8'h5A, 32'd4);
        issue(CMD_SPARE_6, 32'd0, 32'd0, 8'hFF, 32'd0);
        issue(CMD_SPARE_7, 32'd1, 32'd1, 8'hFF, 32'd1);
        // one long copy: smears byte 0 across the whole RAM
        issue(CMD_COPY,    32'd1, 32'd0, 8'h00, 32'hFFFF_FFFF);

        random_phase <= 1'b1;
        for (n = 0; n < RANDOM_ITEMS; n++)
        begin
            p = $urandom_range(0, 99);
            if (p < 16)
                cmd = CMD_BYTE_RD;
            else if (p < 32)
                cmd = CMD_NIB_RD;
            else if (p < 49)
                cmd = CMD_BYTE_WR;
            else if (p < 66)
                cmd = CMD_NIB_WR;
            else if (p < 81)
                cmd = CMD_COPY;
            else if (p < 96)
                cmd = CMD_FILL;
            else
                cmd = $urandom_range(0, 1) ? CMD_SPARE_6 : CMD_SPARE_7;

            if (cmd == CMD_NIB_RD || cmd == CMD_NIB_WR)
                dst = pick_address(2 * RAM_BYTES);
            else
                dst = pick_address(RAM_BYTES);
            src = (cmd == CMD_COPY) ? pick_address(RAM_BYTES) : $urandom();
            val = $urandom_range(0, 255);

            p = $urandom_range(0, 99);
            if (p < 5)
                len = 32'd0;
            else if (p < 75)
                len = $urandom_range(1, 24);
            else if (p < 90)
                len = $urandom_range(25, 300);
            else
            begin
                len = $urandom();
                // keep huge counts cheap: start close to the end so clipping bites
                if (cmd == CMD_COPY || cmd == CMD_FILL)
                    dst = 32'(RAM_BYTES) - $urandom_range(1, 64);
            end
            issue(cmd, dst, src, val, len);
        end
        s_tvalid <= 1'b0;

        while (pending != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);

        if (errors == 0 && pending == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

// ===== files.f =====
design/bnr_pkg.sv
design/bnr_ctrl.sv
design/bnr_datapath.sv
design/byte_nibble_ram_copy_fill_unit.sv
test/bnr_result_checker.sv
test/byte_nibble_ram_copy_fill_unit_tb.sv
